>>> hdl/cda_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and calendar tables for the date arithmetic unit.
package cda_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int CNT_W   = 23;
  localparam int TOT_W   = 22;

  // Internal widths. Day numbers of valid 14-bit years stay below 2^23, and a
  // day number plus a day count stays below 2^24.
  localparam int DN_W    = 23;
  localparam int NUM_W   = 24;
  localparam int DOY_W   = 9;
  localparam int CYR_W   = 15;
  localparam int YCMP_W  = 17;
  localparam int Q100_W  = 8;
  localparam int Q400_W  = 7;
  localparam int R400_W  = 18;
  localparam int R100_W  = 16;
  localparam int Q4_W    = 5;
  localparam int R4_W    = 11;

  // Pipeline depths.
  localparam int D2N_LAT   = 2;
  localparam int N2D_LAT   = 4;
  localparam int VLD_DEPTH = 1 + D2N_LAT + 1 + N2D_LAT;

  // Calendar constants.
  localparam int unsigned DAYS_400Y       = 146097;
  localparam int unsigned DAYS_100Y       = 36524;
  localparam int unsigned DAYS_4Y         = 1461;
  localparam int unsigned DAYS_1Y         = 365;
  localparam int unsigned YEARS_CENT      = 100;
  localparam int unsigned YEARS_QUAD_CENT = 400;
  localparam int unsigned MON_FEB         = 2;
  localparam int unsigned MON_DEC         = 12;

  // Reciprocals for exact floor division by a constant: floor(x / D) equals
  // (x * ceil(2^SH / D)) >> SH when SH is the dividend width plus the divisor width.
  localparam int RCP100_SH = YEAR_W + 7;
  localparam int RCP100_W  = 15;
  localparam longint unsigned RCP100 =
      ((64'd1 << RCP100_SH) + 64'(YEARS_CENT) - 64'd1) / 64'(YEARS_CENT);

  localparam int RCP400Y_SH = NUM_W + 18;
  localparam int RCP400Y_W  = 25;
  localparam longint unsigned RCP400Y =
      ((64'd1 << RCP400Y_SH) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);

  localparam int RCP1461_SH = R100_W + 11;
  localparam int RCP1461_W  = 17;
  localparam longint unsigned RCP1461 =
      ((64'd1 << RCP1461_SH) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DIFF = 2'd1,
    CMD_CMP  = 2'd2,
    CMD_DOY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Day number of a date, its day of year and its validity.
  typedef struct packed {
    logic [DN_W-1:0]  dn;
    logic [DOY_W-1:0] doy;
    logic             ok;
  } date_num_t;

  // Calendar date rebuilt from a day number.
  typedef struct packed {
    logic [CYR_W-1:0] year;
    logic [MON_W-1:0] month;
    logic [DAY_W-1:0] day;
  } cal_date_t;

  // One accepted input beat.
  typedef struct packed {
    cmd_t              cmd;
    logic [YEAR_W-1:0] year_a;
    logic [MON_W-1:0]  month_a;
    logic [DAY_W-1:0]  day_a;
    logic [YEAR_W-1:0] year_b;
    logic [MON_W-1:0]  month_b;
    logic [DAY_W-1:0]  day_b;
    logic [CNT_W-1:0]  cnt;
  } in_beat_t;

  // Command and day count carried alongside the date conversion.
  typedef struct packed {
    cmd_t             cmd;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

  // Results that are final before the date rebuild, carried alongside it.
  typedef struct packed {
    cmd_t             cmd;
    logic             invalid;
    logic             neg;
    logic [TOT_W-1:0] total;
    logic             after;
    logic             equal;
  } side_t;

  // Days in the months before month m of a common year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Length of month m; zero for a month number that names no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                  len = 5'd31;
      default:                                len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/cda_date_to_num.sv
`timescale 1ns / 1ps
// Two-stage conversion of a calendar date to a day number, with validity and day of year.
module cda_date_to_num #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                     clk,
  input  logic [cda_pkg::YEAR_W-1:0] year,
  input  logic [cda_pkg::MON_W-1:0]  month,
  input  logic [cda_pkg::DAY_W-1:0]  day,
  output cda_pkg::date_num_t       num
);
  import cda_pkg::*;

  localparam logic [YCMP_W-1:0] MAX_YEAR_V = YCMP_W'(MAX_YEAR);
  localparam int QP_W = YEAR_W + RCP100_W;

  // Stage 1: year / 100 by reciprocal multiply.
  logic [QP_W-1:0]   q_prod;
  logic [Q100_W-1:0] qy_nxt;

  logic [YEAR_W-1:0] year_r;
  logic [MON_W-1:0]  month_r;
  logic [DAY_W-1:0]  day_r;
  logic [Q100_W-1:0] qy_r;

  assign q_prod = QP_W'(year) * QP_W'(RCP100);
  assign qy_nxt = q_prod[RCP100_SH +: Q100_W];

  always_ff @(posedge clk) begin
    year_r  <= year;
    month_r <= month;
    day_r   <= day;
    qy_r    <= qy_nxt;
  end

  // Stage 2: leap rule, validity and the day number sum.
  logic [YEAR_W-1:0] cent_base;
  logic              cent;
  logic              leap;
  logic [YEAR_W-1:0] p;
  logic [Q100_W-1:0] p100;
  logic [Q100_W-1:0] p400;
  logic [DOY_W-1:0]  doy;
  logic              ok;
  date_num_t         num_nxt;
  date_num_t         num_r;

  assign cent_base = YEAR_W'(qy_r) * YEAR_W'(YEARS_CENT);
  assign cent      = (cent_base == year_r);
  // A year divisible by 100 is a leap year only when year / 100 is divisible by 4.
  assign leap      = (year_r[1:0] == 2'b00) && (!cent || (qy_r[1:0] == 2'b00));

  // Whole years before this one, and the centuries among them.
  assign p    = year_r - YEAR_W'(1);
  assign p100 = qy_r - Q100_W'(cent);
  assign p400 = p100 >> 2;

  assign doy = cum_days(month_r)
             + DOY_W'(leap && (month_r > MON_W'(MON_FEB)))
             + DOY_W'(day_r);

  assign ok = (year_r != '0)
           && (YCMP_W'(year_r) <= MAX_YEAR_V)
           && (month_r != '0)
           && (month_r <= MON_W'(MON_DEC))
           && (day_r != '0)
           && (day_r <= month_len(month_r, leap));

  always_comb begin
    num_nxt.dn  = DN_W'(p) * DN_W'(DAYS_1Y)
                + DN_W'(p >> 2)
                - DN_W'(p100)
                + DN_W'(p400)
                + DN_W'(doy)
                - DN_W'(1);
    num_nxt.doy = doy;
    num_nxt.ok  = ok;
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
  end

  assign num = num_r;

endmodule

>>> hdl/cda_num_to_date.sv
`timescale 1ns / 1ps
// Four-stage rebuild of a calendar date from a non-negative day number.
module cda_num_to_date (
  input  logic                    clk,
  input  logic [cda_pkg::NUM_W-1:0] num,
  output cda_pkg::cal_date_t      date
);
  import cda_pkg::*;

  localparam int P400_W = NUM_W + RCP400Y_W;
  localparam int P4_W   = R100_W + RCP1461_W;

  // Stage 1: number of whole 400-year cycles.
  logic [P400_W-1:0] q400_prod;
  logic [NUM_W-1:0]  n_r1;
  logic [Q400_W-1:0] q400_r1;

  assign q400_prod = P400_W'(num) * P400_W'(RCP400Y);

  always_ff @(posedge clk) begin
    n_r1    <= num;
    q400_r1 <= q400_prod[RCP400Y_SH +: Q400_W];
  end

  // Stage 2: centuries inside the cycle. The last day of a cycle falls in the
  // fourth century, so the count stops at three.
  logic [R400_W-1:0] r400;
  logic [1:0]        c_nxt;
  logic [R100_W-1:0] r100_nxt;
  logic [CYR_W-1:0]  base_nxt;
  logic [R100_W-1:0] r100_r2;
  logic [CYR_W-1:0]  base_r2;
  logic [1:0]        c_r2;

  assign r400  = R400_W'(n_r1 - NUM_W'(q400_r1) * NUM_W'(DAYS_400Y));
  assign c_nxt = 2'(r400 >= R400_W'(DAYS_100Y))
               + 2'(r400 >= R400_W'(2 * DAYS_100Y))
               + 2'(r400 >= R400_W'(3 * DAYS_100Y));
  assign r100_nxt = R100_W'(r400 - R400_W'(c_nxt) * R400_W'(DAYS_100Y));
  assign base_nxt = CYR_W'(q400_r1) * CYR_W'(YEARS_QUAD_CENT)
                  + CYR_W'(c_nxt) * CYR_W'(YEARS_CENT);

  always_ff @(posedge clk) begin
    r100_r2 <= r100_nxt;
    base_r2 <= base_nxt;
    c_r2    <= c_nxt;
  end

  // Stage 3: four-year groups inside the century.
  logic [P4_W-1:0]   q4_prod;
  logic [Q4_W-1:0]   q4_r3;
  logic [R100_W-1:0] r100_r3;
  logic [CYR_W-1:0]  base_r3;
  logic [1:0]        c_r3;

  assign q4_prod = P4_W'(r100_r2) * P4_W'(RCP1461);

  always_ff @(posedge clk) begin
    q4_r3   <= q4_prod[RCP1461_SH +: Q4_W];
    r100_r3 <= r100_r2;
    base_r3 <= base_r2;
    c_r3    <= c_r2;
  end

  // Stage 4: year inside the group, final year and its leap flag.
  logic [R4_W-1:0]  r4;
  logic [1:0]       y1;
  logic [DOY_W-1:0] rday_nxt;
  logic [CYR_W-1:0] yr_nxt;
  logic             leap_nxt;
  logic [DOY_W-1:0] rday_r4;
  logic [CYR_W-1:0] yr_r4;
  logic             leap_r4;

  assign r4 = R4_W'(r100_r3 - R100_W'(q4_r3) * R100_W'(DAYS_4Y));
  assign y1 = 2'(r4 >= R4_W'(DAYS_1Y))
            + 2'(r4 >= R4_W'(2 * DAYS_1Y))
            + 2'(r4 >= R4_W'(3 * DAYS_1Y));
  assign rday_nxt = DOY_W'(r4 - R4_W'(y1) * R4_W'(DAYS_1Y));
  assign yr_nxt   = base_r3 + CYR_W'({q4_r3, 2'b00}) + CYR_W'(y1) + CYR_W'(1);
  // The last year of a four-year group is a leap year, except the century year
  // that closes one of the first three centuries of a cycle.
  assign leap_nxt = (y1 == 2'd3) && ((q4_r3 != Q4_W'(24)) || (c_r3 == 2'd3));

  always_ff @(posedge clk) begin
    rday_r4 <= rday_nxt;
    yr_r4   <= yr_nxt;
    leap_r4 <= leap_nxt;
  end

  // Month search: compare the day of year against every month start at once.
  always_comb begin
    logic [DOY_W-1:0] st;
    logic [DOY_W-1:0] start;
    logic [MON_W-1:0] mo;
    start = '0;
    mo    = MON_W'(1);
    for (int i = MON_FEB; i <= MON_DEC; i++) begin
      st = cum_days(MON_W'(i)) + DOY_W'(leap_r4 && (i > MON_FEB));
      if (rday_r4 >= st) begin
        mo    = MON_W'(i);
        start = st;
      end
    end
    date.year  = yr_r4;
    date.month = mo;
    date.day   = DAY_W'(rday_r4 - start + DOY_W'(1));
  end

endmodule

>>> hdl/calendar_date_arithmetic_unit.sv
`timescale 1ns / 1ps
// Throughput: one beat per clock; busy is high only during reset and for the
// first cycle after it, so start may be held high continuously.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset (rst_n low, synchronous) clears every valid flag; beats in flight are dropped.
module calendar_date_arithmetic_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic [cda_pkg::YEAR_W-1:0]   in_year_a,
  input  logic [cda_pkg::MON_W-1:0]    in_month_a,
  input  logic [cda_pkg::DAY_W-1:0]    in_day_a,
  input  logic [cda_pkg::YEAR_W-1:0]   in_year_b,
  input  logic [cda_pkg::MON_W-1:0]    in_month_b,
  input  logic [cda_pkg::DAY_W-1:0]    in_day_b,
  input  logic [cda_pkg::CNT_W-1:0]    in_day_count,
  output logic                         out_valid,
  output logic [cda_pkg::YEAR_W-1:0]   out_res_year,
  output logic [cda_pkg::MON_W-1:0]    out_res_month,
  output logic [cda_pkg::DAY_W-1:0]    out_res_day,
  output logic [cda_pkg::TOT_W-1:0]    out_day_total,
  output logic                         out_a_after_b,
  output logic                         out_a_equals_b,
  output logic [1:0]                   out_status
);
  import cda_pkg::*;

  // The datapath is a straight pipeline with no back pressure:
  //   stage 0      input register
  //   stages 1-2   both dates become day numbers counted from 0001-01-01
  //   stage 3      add the day count, take the difference and the comparison
  //   stages 4-7   the sum is rebuilt into year, month and day
  //   stage 8      output register, which also merges status and zeroes fields
  // Every beat walks the same path, so results leave in acceptance order.

  localparam logic [YCMP_W-1:0] MAX_YEAR_V = YCMP_W'(MAX_YEAR);

  logic accept;
  logic busy_r;

  // Busy only reflects reset; the pipeline never needs to hold off a beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r | ~rst_n;
  assign accept = start & ~busy;

  // One valid flag per stage, shifted along with the payload.
  logic [VLD_DEPTH-1:0] vld_r;
  logic [VLD_DEPTH-1:0] vld_nxt;

  assign vld_nxt = {vld_r[VLD_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 0: input register.
  in_beat_t beat_r;
  in_beat_t beat_nxt;

  always_comb begin
    beat_nxt.cmd     = cmd_t'(in_cmd);
    beat_nxt.year_a  = in_year_a;
    beat_nxt.month_a = in_month_a;
    beat_nxt.day_a   = in_day_a;
    beat_nxt.year_b  = in_year_b;
    beat_nxt.month_b = in_month_b;
    beat_nxt.day_b   = in_day_b;
    beat_nxt.cnt     = in_day_count;
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  // Stages 1-2: the two date converters, with the command and count riding
  // alongside in a short delay line.
  date_num_t num_a;
  date_num_t num_b;
  ctl_t      ctl_r [D2N_LAT];

  cda_date_to_num #(
    .MAX_YEAR (MAX_YEAR)
  ) u_d2n_a (
    .clk   (clk),
    .year  (beat_r.year_a),
    .month (beat_r.month_a),
    .day   (beat_r.day_a),
    .num   (num_a)
  );

  cda_date_to_num #(
    .MAX_YEAR (MAX_YEAR)
  ) u_d2n_b (
    .clk   (clk),
    .year  (beat_r.year_b),
    .month (beat_r.month_b),
    .day   (beat_r.day_b),
    .num   (num_b)
  );

  always_ff @(posedge clk) begin
    ctl_r[0].cmd <= beat_r.cmd;
    ctl_r[0].cnt <= beat_r.cnt;
    for (int i = 1; i < D2N_LAT; i++) begin
      ctl_r[i] <= ctl_r[i-1];
    end
  end

  // Stage 3: everything that needs only the two day numbers is settled here.
  // A negative count that moves before 0001-01-01 shows up as a negative sum.
  ctl_t             ctl3;
  logic [NUM_W:0]   n_full;
  logic [DN_W-1:0]  d_ab;
  logic [DN_W-1:0]  d_ba;
  logic             a_gt_b;
  logic             a_eq_b;
  logic [DN_W-1:0]  mag;
  logic [TOT_W-1:0] sat_diff;
  side_t            side_nxt;
  side_t            side3_r;
  logic [NUM_W-1:0] n_r;

  assign ctl3   = ctl_r[D2N_LAT-1];
  assign n_full = {2'b00, num_a.dn} + {{(NUM_W + 1 - CNT_W){ctl3.cnt[CNT_W-1]}}, ctl3.cnt};
  assign d_ab   = num_a.dn - num_b.dn;
  assign d_ba   = num_b.dn - num_a.dn;
  assign a_gt_b = num_a.dn > num_b.dn;
  assign a_eq_b = num_a.dn == num_b.dn;
  assign mag    = a_gt_b ? d_ab : d_ba;
  // A gap wider than the total field saturates at its all-ones value.
  assign sat_diff = mag[DN_W-1] ? '1 : mag[TOT_W-1:0];

  always_comb begin
    side_nxt.cmd     = ctl3.cmd;
    side_nxt.invalid = !num_a.ok
                    || (((ctl3.cmd == CMD_DIFF) || (ctl3.cmd == CMD_CMP)) && !num_b.ok);
    side_nxt.neg     = n_full[NUM_W];
    side_nxt.total   = '0;
    side_nxt.after   = 1'b0;
    side_nxt.equal   = 1'b0;
    case (ctl3.cmd)
      CMD_DIFF: side_nxt.total = sat_diff;
      CMD_DOY:  side_nxt.total = TOT_W'(num_a.doy);
      CMD_CMP: begin
        side_nxt.after = a_gt_b;
        side_nxt.equal = a_eq_b;
      end
      default: side_nxt.total = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    side3_r <= side_nxt;
    n_r     <= n_full[NUM_W-1:0];
  end

  // Stages 4-7: rebuild the date; the settled results wait in step with it.
  cal_date_t date;
  side_t     side_r [N2D_LAT];

  cda_num_to_date u_n2d (
    .clk  (clk),
    .num  (n_r),
    .date (date)
  );

  always_ff @(posedge clk) begin
    side_r[0] <= side3_r;
    for (int i = 1; i < N2D_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Stage 8: status priority is invalid input first, then a result year out of
  // range. Any flagged beat leaves every other field at zero.
  side_t             sd;
  status_t           status_nxt;
  logic [YEAR_W-1:0] year_nxt;
  logic [MON_W-1:0]  month_nxt;
  logic [DAY_W-1:0]  day_nxt;
  logic [TOT_W-1:0]  total_nxt;
  logic              after_nxt;
  logic              equal_nxt;

  assign sd = side_r[N2D_LAT-1];

  always_comb begin
    status_nxt = ST_OK;
    year_nxt   = '0;
    month_nxt  = '0;
    day_nxt    = '0;
    total_nxt  = '0;
    after_nxt  = 1'b0;
    equal_nxt  = 1'b0;
    if (sd.invalid) begin
      status_nxt = ST_INVALID;
    end else if ((sd.cmd == CMD_ADD)
                 && (sd.neg || (YCMP_W'(date.year) > MAX_YEAR_V))) begin
      status_nxt = ST_RANGE;
    end else begin
      if (sd.cmd == CMD_ADD) begin
        year_nxt  = date.year[YEAR_W-1:0];
        month_nxt = date.month;
        day_nxt   = date.day;
      end
      total_nxt = sd.total;
      after_nxt = sd.after;
      equal_nxt = sd.equal;
    end
  end

  logic              out_valid_r;
  status_t           status_r;
  logic [YEAR_W-1:0] year_r;
  logic [MON_W-1:0]  month_r;
  logic [DAY_W-1:0]  day_r;
  logic [TOT_W-1:0]  total_r;
  logic              after_r;
  logic              equal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[VLD_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    total_r  <= total_nxt;
    after_r  <= after_nxt;
    equal_r  <= equal_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_res_year   = year_r;
  assign out_res_month  = month_r;
  assign out_res_day    = day_r;
  assign out_day_total  = total_r;
  assign out_a_after_b  = after_r;
  assign out_a_equals_b = equal_r;

  // Every accepted beat produces its result strobe.
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(VLD_DEPTH + 1) out_valid)
    else $error("accepted beat produced no result strobe");

  // No strobe appears without a matching accepted beat.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, VLD_DEPTH + 1))
    else $error("result strobe without an accepted beat");

  // A flagged result carries zeros in every other field.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_res_year == '0) && (out_res_month == '0) && (out_res_day == '0)
       && (out_day_total == '0) && !out_a_after_b && !out_a_equals_b))
    else $error("flagged result with nonzero fields");

  // A rebuilt date always has a month of 1 to 12, a nonzero day and year, and an OK status.
  a_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res_month != '0)) |->
      ((out_res_month <= MON_W'(MON_DEC)) && (out_res_day != '0)
       && (out_res_year != '0) && (out_status == ST_OK)))
    else $error("malformed result date");

endmodule
